@@ rtl/ppr_pkg.sv @@
`timescale 1ns / 1ps
// Package for the prime power period reduction block: widths, codes and the
// request/response structs between the sequencer and the arithmetic unit.
// No dependencies.
package ppr_pkg;

    localparam int VALUE_WIDTH  = 63;
    localparam int MAX_EXPONENT = 63;
    localparam int DW           = 64;
    localparam int A_W          = 63;
    localparam int BASE_W       = 32;
    localparam int EXP_W        = 6;
    localparam int OFF_W        = 32;
    localparam int ADDR_W       = 4;
    localparam int PDATA_W      = 32;
    localparam int CNT_W        = $clog2(DW);

    localparam logic [DW-1:0] VMASK = (64'd1 << VALUE_WIDTH) - 64'd1;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FORM  = 3'd1;
    localparam logic [2:0] ST_EVEN  = 3'd2;
    localparam logic [2:0] ST_LIMIT = 3'd3;
    localparam logic [2:0] ST_OVF   = 3'd4;

    localparam logic [1:0] REG_BASE = 2'd0;
    localparam logic [1:0] REG_EXP  = 2'd1;
    localparam logic [1:0] REG_OFF  = 2'd2;

    typedef enum logic [1:0] {
        MDU_MUL    = 2'd0,
        MDU_MULMOD = 2'd1,
        MDU_DIV    = 2'd2
    } mdu_op_t;

    typedef struct packed {
        logic          start;
        mdu_op_t       op;
        logic [DW-1:0] x;
        logic [DW-1:0] y;
        logic [DW-1:0] n;
    } mdu_req_t;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic          ovf;
        logic [DW-1:0] res;
        logic [DW-1:0] rem;
    } mdu_rsp_t;

endpackage

@@ rtl/ppr_mdu.sv @@
`timescale 1ns / 1ps
// Bit-serial arithmetic unit: saturating multiply, modular multiply and
// restoring division, one bit per step over a 65-bit adder and subtractor.
// Depends on ppr_pkg.
module ppr_mdu
    import ppr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mdu_req_t req,
    output mdu_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ovf_reg, ovf_next;
    logic             ph_reg, ph_next;
    mdu_op_t          op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    x_reg, x_next;
    logic [DW-1:0]    n_reg, n_next;
    logic [DW-1:0]    y_reg, y_next;
    logic [DW:0]      acc_reg, acc_next;

    logic [DW:0] opnd;
    logic [DW:0] sum;
    logic [DW:0] diff;
    logic        ge;
    logic        advance;

    always_comb
    begin
        opnd = '0;
        sum  = '0;
        unique case (op_reg)
            MDU_MUL:
            begin
                opnd = y_reg[DW-1] ? {1'b0, x_reg} : '0;
                sum  = {acc_reg[DW-1:0], 1'b0} + opnd;
            end
            MDU_MULMOD:
            begin
                opnd = ph_reg ? {1'b0, x_reg} : acc_reg;
                sum  = acc_reg + opnd;
            end
            MDU_DIV:
            begin
                sum = {acc_reg[DW-1:0], y_reg[DW-1]};
            end
            default:
            begin
                sum = '0;
            end
        endcase
        ge   = (sum >= {1'b0, n_reg});
        diff = sum - {1'b0, n_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        ph_next   = ph_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        n_next    = n_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        advance   = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            ovf_next  = 1'b0;
            ph_next   = 1'b0;
            op_next   = req.op;
            cnt_next  = '1;
            x_next    = req.x;
            n_next    = req.n;
            y_next    = (req.op == MDU_DIV) ? req.x : req.y;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                MDU_MUL:
                begin
                    // clamp just above the limit once exceeded
                    if (sum > {1'b0, VMASK})
                    begin
                        ovf_next = 1'b1;
                        acc_next = {1'b0, VMASK} + 1'b1;
                    end
                    else
                    begin
                        acc_next = sum;
                    end
                    advance = 1'b1;
                end
                MDU_MULMOD:
                begin
                    acc_next = ge ? diff : sum;
                    if (!ph_reg && y_reg[DW-1])
                    begin
                        ph_next = 1'b1;
                    end
                    else
                    begin
                        ph_next = 1'b0;
                        advance = 1'b1;
                    end
                end
                MDU_DIV:
                begin
                    acc_next = ge ? diff : sum;
                    advance  = 1'b1;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
            if (advance)
            begin
                if (op_reg == MDU_DIV)
                begin
                    y_next = {y_reg[DW-2:0], ge};
                end
                else
                begin
                    y_next = {y_reg[DW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        ph_reg  <= ph_next;
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        x_reg   <= x_next;
        n_reg   <= n_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.res  = (op_reg == MDU_DIV) ? y_reg : acc_reg[DW-1:0];
    assign rsp.rem  = acc_reg[DW-1:0];

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without a running operation");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !req.start |=> !done_reg)
        else $error("done held longer than one cycle");

    a_mulmod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && op_reg == MDU_MULMOD |-> acc_reg < {1'b0, n_reg})
        else $error("modular accumulator left its range");

endmodule

@@ rtl/prime_power_period_reduction.sv @@
`timescale 1ns / 1ps
// Top level: configuration registers, sequencer and result register around
// the shared bit-serial arithmetic unit. Depends on ppr_pkg and ppr_mdu.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   config   | psel penable pready  | paddr pwrite pwdata prdata
//   mult     | mult_valid/stall     | multiplier
//   result   | res_valid/stall      | reduced_modulus max_period status
//
// One transaction at a time. Each ppr_mdu operation is an issue, one step per
// bit, then done; a modular multiply takes one more step per set bit of its
// second operand. Forming b^e takes one multiply per power (e powers). Base
// two then scans the powers up to e. Other bases take, for each tried power
// k, a division to reduce a, 32 squarings plus one multiply per set bit of
// b-1 with one step state per bit, and a multiply for the next power; a final
// division gives the result.
// Reset is asynchronous; no clearing pass. A stalled result waits in its
// register while the next transaction is taken.
module prime_power_period_reduction
    import ppr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               mult_valid,
    output logic               mult_stall,
    input  logic [A_W-1:0]     multiplier,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [A_W-1:0]     reduced_modulus,
    output logic               max_period,
    output logic [2:0]         status
);

    typedef enum logic [20:0] {
        S_IDLE   = 21'h000001,
        S_POW    = 21'h000002,
        S_POW_W  = 21'h000004,
        S_OFFS   = 21'h000008,
        S_CLASS  = 21'h000010,
        S_TWO    = 21'h000020,
        S_SCAN   = 21'h000040,
        S_SQ     = 21'h000080,
        S_RED    = 21'h000100,
        S_RED_W  = 21'h000200,
        S_SQR    = 21'h000400,
        S_SQR_W  = 21'h000800,
        S_MULX   = 21'h001000,
        S_MULX_W = 21'h002000,
        S_STEP   = 21'h004000,
        S_TEST   = 21'h008000,
        S_NEXT   = 21'h010000,
        S_NEXT_W = 21'h020000,
        S_QUO    = 21'h040000,
        S_QUO_W  = 21'h080000,
        S_OUT    = 21'h100000
    } state_t;

    typedef struct packed {
        logic [DW-1:0] red;
        logic          maxp;
        logic [2:0]    st;
    } pend_t;

    function automatic pend_t mk(logic [DW-1:0] red, logic maxp, logic [2:0] st);
        pend_t p;
        p.red  = red;
        p.maxp = maxp;
        p.st   = st;
        return p;
    endfunction

    state_t            state_reg, state_next;
    logic [BASE_W-1:0] base_reg;
    logic [EXP_W-1:0]  exp_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [A_W-1:0]    a_reg, a_next;
    logic [DW-1:0]     m_reg, m_next;
    logic [DW-1:0]     n_reg, n_next;
    logic [DW-1:0]     prev_reg, prev_next;
    logic [DW-1:0]     xm_reg, xm_next;
    logic [DW-1:0]     r_reg, r_next;
    logic [DW-1:0]     t_reg, t_next;
    logic [EXP_W:0]    k_reg, k_next;
    logic [4:0]        bit_reg, bit_next;
    logic              flag_reg, flag_next;
    pend_t             pend_reg, pend_next;
    logic              res_valid_reg, res_valid_next;
    pend_t             out_reg, out_next;

    mdu_req_t          req;
    mdu_rsp_t          rsp;

    logic              cfg_wr;
    logic [BASE_W-1:0] bm1;
    logic [OFF_W:0]    neg;
    logic [DW-1:0]     kmask;
    logic [EXP_W:0]    e_ext;
    logic [EXP_W:0]    k_inc;
    logic [DW-1:0]     sq;

    ppr_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BASE: prdata = base_reg;
            REG_EXP:  prdata = {{(PDATA_W-EXP_W){1'b0}}, exp_reg};
            REG_OFF:  prdata = off_reg;
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_W'(2);
            exp_reg  <= EXP_W'(31);
            off_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_BASE: base_reg <= pwdata[BASE_W-1:0];
                REG_EXP:  exp_reg  <= pwdata[EXP_W-1:0];
                REG_OFF:  off_reg  <= pwdata[OFF_W-1:0];
                default:  ;
            endcase
        end
    end

    assign bm1   = base_reg - 1'b1;
    assign neg   = {1'b1, {OFF_W{1'b0}}} - {1'b0, off_reg};
    assign kmask = (64'd1 << k_reg) - 64'd1;
    assign e_ext = {1'b0, exp_reg};
    assign k_inc = k_reg + 1'b1;
    // upper halves are zero: a 32 by 32 product kept at full width
    assign sq    = {{(DW-BASE_W){1'b0}}, base_reg} * {{(DW-BASE_W){1'b0}}, base_reg};

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        prev_next      = prev_reg;
        xm_next        = xm_reg;
        r_next         = r_reg;
        t_next         = t_reg;
        k_next         = k_reg;
        bit_next       = bit_reg;
        flag_next      = flag_reg;
        pend_next      = pend_reg;
        res_valid_next = res_valid_reg;
        out_next       = out_reg;
        req            = '0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (mult_valid)
                begin
                    a_next = multiplier;
                    if (exp_reg == '0)
                    begin
                        m_next     = {{(DW-BASE_W){1'b0}}, base_reg};
                        state_next = S_CLASS;
                    end
                    else if (exp_reg > EXP_W'(MAX_EXPONENT))
                    begin
                        pend_next  = mk('0, 1'b0, ST_OVF);
                        state_next = S_OUT;
                    end
                    else if (base_reg < BASE_W'(2))
                    begin
                        m_next     = {{(DW-BASE_W){1'b0}}, base_reg};
                        state_next = S_OFFS;
                    end
                    else
                    begin
                        m_next     = DW'(1);
                        k_next     = '0;
                        state_next = S_POW;
                    end
                end
            end
            S_POW:
            begin
                req.start  = 1'b1;
                req.op     = MDU_MUL;
                req.x      = m_reg;
                req.y      = {{(DW-BASE_W){1'b0}}, base_reg};
                state_next = S_POW_W;
            end
            S_POW_W:
            begin
                if (rsp.done)
                begin
                    if (rsp.ovf)
                    begin
                        pend_next  = mk('0, 1'b0, ST_OVF);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        m_next     = rsp.res;
                        k_next     = k_inc;
                        state_next = (k_inc == e_ext) ? S_OFFS : S_POW;
                    end
                end
            end
            S_OFFS:
            begin
                state_next = S_CLASS;
                if (off_reg[OFF_W-1])
                begin
                    if ({{(DW-OFF_W-1){1'b0}}, neg} > m_reg)
                    begin
                        pend_next  = mk('0, 1'b0, ST_OVF);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        m_next = m_reg - {{(DW-OFF_W-1){1'b0}}, neg};
                    end
                end
                else
                begin
                    m_next = m_reg + {{(DW-OFF_W){1'b0}}, off_reg};
                end
            end
            S_CLASS:
            begin
                state_next = S_OUT;
                if (m_reg > VMASK)
                begin
                    pend_next = mk('0, 1'b0, ST_OVF);
                end
                else if (exp_reg == '0 || off_reg != '0 || base_reg < BASE_W'(2))
                begin
                    pend_next = mk(m_reg, 1'b0, ST_FORM);
                end
                else if (base_reg == BASE_W'(2))
                begin
                    state_next = S_TWO;
                end
                else
                begin
                    state_next = S_SQ;
                end
            end
            S_TWO:
            begin
                k_next     = (EXP_W+1)'(4);
                state_next = S_SCAN;
                unique case (a_reg[2:0])
                    3'd5:
                    begin
                        pend_next  = mk(m_reg >> 2, 1'b1, ST_OK);
                        state_next = S_OUT;
                    end
                    3'd3:
                    begin
                        pend_next  = mk(m_reg >> 3, 1'b1, ST_OK);
                        state_next = S_OUT;
                    end
                    3'd1:    t_next = {1'b0, a_reg} - 1'b1;
                    3'd7:    t_next = {1'b0, a_reg} + 1'b1;
                    default:
                    begin
                        pend_next  = mk('0, 1'b0, ST_EVEN);
                        state_next = S_OUT;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (k_reg > e_ext)
                begin
                    pend_next  = mk('0, 1'b0, ST_LIMIT);
                    state_next = S_OUT;
                end
                else if ((t_reg & kmask) != '0)
                begin
                    pend_next  = mk(m_reg >> k_reg, 1'b0, ST_OK);
                    state_next = S_OUT;
                end
                else
                begin
                    k_next = k_inc;
                end
            end
            S_SQ:
            begin
                n_next     = sq;
                prev_next  = {{(DW-BASE_W){1'b0}}, base_reg};
                k_next     = (EXP_W+1)'(2);
                state_next = S_RED;
            end
            S_RED:
            begin
                req.start  = 1'b1;
                req.op     = MDU_DIV;
                req.x      = {1'b0, a_reg};
                req.n      = n_reg;
                state_next = S_RED_W;
            end
            S_RED_W:
            begin
                if (rsp.done)
                begin
                    xm_next    = rsp.rem;
                    r_next     = DW'(1);
                    bit_next   = '1;
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                req.start  = 1'b1;
                req.op     = MDU_MULMOD;
                req.x      = r_reg;
                req.y      = r_reg;
                req.n      = n_reg;
                state_next = S_SQR_W;
            end
            S_SQR_W:
            begin
                if (rsp.done)
                begin
                    r_next     = rsp.res;
                    state_next = bm1[bit_reg] ? S_MULX : S_STEP;
                end
            end
            S_MULX:
            begin
                req.start  = 1'b1;
                req.op     = MDU_MULMOD;
                req.x      = r_reg;
                req.y      = xm_reg;
                req.n      = n_reg;
                state_next = S_MULX_W;
            end
            S_MULX_W:
            begin
                if (rsp.done)
                begin
                    r_next     = rsp.res;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (bit_reg == '0)
                begin
                    state_next = S_TEST;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = S_SQR;
                end
            end
            S_TEST:
            begin
                if (r_reg != DW'(1))
                begin
                    flag_next  = (k_reg == (EXP_W+1)'(2));
                    state_next = S_QUO;
                end
                else if (k_inc > e_ext)
                begin
                    pend_next  = mk('0, 1'b0, ST_LIMIT);
                    state_next = S_OUT;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                prev_next  = n_reg;
                req.start  = 1'b1;
                req.op     = MDU_MUL;
                req.x      = n_reg;
                req.y      = {{(DW-BASE_W){1'b0}}, base_reg};
                state_next = S_NEXT_W;
            end
            S_NEXT_W:
            begin
                if (rsp.done)
                begin
                    n_next     = rsp.res;
                    state_next = S_RED;
                end
            end
            S_QUO:
            begin
                req.start  = 1'b1;
                req.op     = MDU_DIV;
                req.x      = m_reg;
                req.n      = prev_reg;
                state_next = S_QUO_W;
            end
            S_QUO_W:
            begin
                if (rsp.done)
                begin
                    pend_next  = mk(rsp.res, flag_reg, ST_OK);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // load the result register once it is free
                if (!res_valid_reg || !res_stall)
                begin
                    out_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        m_reg    <= m_next;
        n_reg    <= n_next;
        prev_reg <= prev_next;
        xm_reg   <= xm_next;
        r_reg    <= r_next;
        t_reg    <= t_next;
        k_reg    <= k_next;
        bit_reg  <= bit_next;
        flag_reg <= flag_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign mult_stall      = (state_reg != S_IDLE);
    assign res_valid       = res_valid_reg;
    assign reduced_modulus = out_reg.red[A_W-1:0];
    assign max_period      = out_reg.maxp;
    assign status          = out_reg.st;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !rsp.busy)
        else $error("arithmetic unit started while busy");

    a_err_no_maxp: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && out_reg.st != ST_OK |-> !out_reg.maxp)
        else $error("max_period set on a failed transaction");

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (out_reg.st == ST_OVF || out_reg.st == ST_EVEN
            || out_reg.st == ST_LIMIT) |-> out_reg.red == '0)
        else $error("nonzero modulus on an error result");

endmodule
